@@ rtl/msel_pkg.sv @@
// Shared types, codes and helper functions for the MIDI preset selector.
`timescale 1ns / 1ps

package msel_pkg;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam int unsigned FIELD_W = 7;

  // XG drum bank select values and the melodic-fallback LSB that skips the wide match
  localparam logic [FIELD_W-1:0] XG_DRUM_MSB_A = 7'd120;
  localparam logic [FIELD_W-1:0] XG_DRUM_MSB_B = 7'd127;
  localparam logic [FIELD_W-1:0] XG_SFX_LSB    = 7'd64;

  // One stored preset entry, program in the lowest bits
  typedef struct packed {
    logic               gm_drum;
    logic [FIELD_W-1:0] lsb;
    logic [FIELD_W-1:0] msb;
    logic [FIELD_W-1:0] prog;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Lookup request as held for the whole table scan
  typedef struct packed {
    logic [FIELD_W-1:0] prog;
    logic [FIELD_W-1:0] msb;
    logic [FIELD_W-1:0] lsb;
    logic [FIELD_W-1:0] want;      // larger of request MSB and LSB
    logic               drum_ch;
    logic               is_xg;
    logic               xg_drums;  // XG system and drum bank MSB
    logic               bank_ok;   // table is a valid XG bank
    logic               wide_en;   // wide bank match pass enabled
  } req_t;

  function automatic logic is_xg_msb(input logic [FIELD_W-1:0] msb);
    return (msb == XG_DRUM_MSB_A) || (msb == XG_DRUM_MSB_B);
  endfunction

  // Programs allowed in an XG drum bank
  function automatic logic xg_allowed(input logic [FIELD_W-1:0] prog);
    logic ok;
    case (prog)
      7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9: ok = 1'b1;
      7'd16, 7'd17: ok = 1'b1;
      7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31: ok = 1'b1;
      7'd32, 7'd33, 7'd40, 7'd41, 7'd48: ok = 1'b1;
      7'd56, 7'd57, 7'd58, 7'd64, 7'd65, 7'd66: ok = 1'b1;
      7'd126, 7'd127: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

@@ rtl/msel_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module msel_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, and read one word into the registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/msel_scan.sv @@
// Ordered table scan: tracks the first hit of every fallback pass and picks the winner.
`timescale 1ns / 1ps

module msel_scan #(
  parameter int AW = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  msel_pkg::req_t   req,
  input  logic             ent_valid,
  input  logic [AW-1:0]    ent_idx,
  input  msel_pkg::entry_t ent,
  output logic [AW-1:0]    result_idx
);

  // Pass order: A1 drum program, A2 any drum, B1 XG drum program, B2 any XG drum,
  // C1 melodic bank, C2 melodic wide bank, C3 first melodic
  localparam int P_A1 = 0;
  localparam int P_A2 = 1;
  localparam int P_B1 = 2;
  localparam int P_B2 = 3;
  localparam int P_C1 = 4;
  localparam int P_C2 = 5;
  localparam int P_C3 = 6;
  localparam int NPASS = 7;

  logic             ex_seen;
  logic             ex_ok;
  logic [AW-1:0]    ex_idx;
  logic [NPASS-1:0] found;
  logic [AW-1:0]    hit_idx [NPASS];

  logic             xgd;
  logic             prog_eq;
  logic             mel;
  logic             ex_hit;
  logic [NPASS-1:0] hit;

  // Classify the entry arriving from the table
  always_comb begin
    xgd     = req.bank_ok && msel_pkg::is_xg_msb(ent.msb);
    prog_eq = (ent.prog == req.prog);
    mel     = prog_eq && !ent.gm_drum && !xgd;
    ex_hit  = (!req.drum_ch || ent.gm_drum || req.xg_drums) && prog_eq &&
              (ent.lsb == req.lsb) && (ent.msb == req.msb);
    hit[P_A1] = ent.gm_drum && prog_eq;
    hit[P_A2] = ent.gm_drum || (req.is_xg && xgd);
    hit[P_B1] = prog_eq && xgd;
    hit[P_B2] = ent.gm_drum || xgd;
    hit[P_C1] = mel && (req.is_xg ? (ent.lsb == req.lsb) : (ent.msb == req.msb));
    hit[P_C2] = mel && ((ent.lsb == req.want) || (ent.msb == req.want));
    hit[P_C3] = mel;
  end

  // Keep the first exact candidate and whether it may be taken
  always_ff @(posedge clk) begin
    if (rst || start) begin
      ex_seen <= 1'b0;
    end else if (ent_valid && ex_hit && !ex_seen) begin
      ex_seen <= 1'b1;
    end
    if (ent_valid && ex_hit && !ex_seen) begin
      ex_ok  <= !req.xg_drums || xgd;
      ex_idx <= ent_idx;
    end
  end

  // Hold the lowest index of each fallback pass
  always_ff @(posedge clk) begin
    if (rst || start) begin
      found <= '0;
    end else if (ent_valid) begin
      found <= found | hit;
    end
  end

  for (genvar p = 0; p < NPASS; p++) begin : g_pass
    always_ff @(posedge clk) begin
      if (ent_valid && hit[p] && !found[p]) begin
        hit_idx[p] <= ent_idx;
      end
    end
  end

  // Resolve the fallback order
  always_comb begin
    if (ex_seen && ex_ok) begin
      result_idx = ex_idx;
    end else if (req.drum_ch && found[P_A1]) begin
      result_idx = hit_idx[P_A1];
    end else if (req.drum_ch && found[P_A2]) begin
      result_idx = hit_idx[P_A2];
    end else if (req.xg_drums && found[P_B1]) begin
      result_idx = hit_idx[P_B1];
    end else if (req.xg_drums && found[P_B2]) begin
      result_idx = hit_idx[P_B2];
    end else if (found[P_C1]) begin
      result_idx = hit_idx[P_C1];
    end else if (req.wide_en && found[P_C2]) begin
      result_idx = hit_idx[P_C2];
    end else if (found[P_C3]) begin
      result_idx = hit_idx[P_C3];
    end else begin
      result_idx = '0;
    end
  end

endmodule

@@ rtl/midi_preset_select.sv @@
// Top level of the MIDI preset selector: command handling, table RAM and result register.
`timescale 1ns / 1ps

// Preset table of up to MAX_PRESETS entries held in one RAM. A load or a clear
// leaves s_tready high, so the next beat can be taken in the following cycle; a
// load beyond capacity is dropped. A lookup walks the table once in index order
// through the RAM read port, one entry a cycle. It holds s_tready low through the
// scan, the last read in flight and the done state until the result beat is
// registered; the single read port sets the scan rate, and a result beat still
// waiting for m_tready stretches the wait. Every lookup returns one result beat;
// table_empty is set when the table holds no entries, and preset_index then reads
// zero. Loads and clears return nothing. The user writes xg_system through cfg_we
// and cfg_wdata only while the block is idle; the block does not enforce this.
module midi_preset_select #(
  parameter int MAX_PRESETS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // xg_system
  input  logic        s_tvalid,
  output logic        s_tready,
  // [6:0] program_req, [13:7] bank select MSB, [20:14] bank select LSB,
  // [21] gm_gs_drum, [22] drum_channel, [23] zero
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,        // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,        // [8:0] preset_index, [15:9] zero
  output logic        m_tuser         // [0] table_empty
);

  localparam int AW = (MAX_PRESETS > 1) ? $clog2(MAX_PRESETS) : 1;
  localparam int CW = $clog2(MAX_PRESETS + 1);
  localparam int IDX_W = 9;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic              xg_system;
  logic [CW-1:0]     count;
  logic              bank_seen;
  logic              bank_invalid;
  logic [CW-1:0]     rd_ptr;
  logic              rd_pend;
  logic [AW-1:0]     rd_idx;
  msel_pkg::req_t    req;
  msel_pkg::req_t    req_next;
  msel_pkg::entry_t  in_ent;
  msel_pkg::entry_t  rd_ent;
  logic [msel_pkg::ENTRY_W-1:0] rd_word;
  logic [AW-1:0]     result_idx;
  logic [AW+IDX_W-1:0] result_wide;
  logic [IDX_W-1:0]  out_idx;
  logic              out_empty;

  logic              accept;
  logic              do_load;
  logic              do_clear;
  logic              do_lookup;
  logic              rd_issue;
  logic              out_free;
  logic              drum_ch_in;

  // Unpack the input beat
  always_comb begin
    in_ent.prog    = s_tdata[6:0];
    in_ent.msb     = s_tdata[13:7];
    in_ent.lsb     = s_tdata[20:14];
    in_ent.gm_drum = s_tdata[21];
    drum_ch_in     = s_tdata[22];
  end

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign do_load   = accept && (s_tuser == msel_pkg::CMD_LOAD) &&
                     (count < CW'(MAX_PRESETS));
  assign do_clear  = accept && (s_tuser == msel_pkg::CMD_CLEAR);
  assign do_lookup = accept && (s_tuser == msel_pkg::CMD_LOOKUP);
  assign rd_issue  = (state == ST_SCAN) && (rd_ptr != count);
  assign out_free  = !m_tvalid || m_tready;

  // Build the lookup request from the beat and the bank flags
  always_comb begin
    req_next.prog     = in_ent.prog;
    req_next.msb      = in_ent.msb;
    req_next.lsb      = in_ent.lsb;
    req_next.want     = (in_ent.msb > in_ent.lsb) ? in_ent.msb : in_ent.lsb;
    req_next.drum_ch  = drum_ch_in;
    req_next.is_xg    = xg_system;
    req_next.xg_drums = xg_system && msel_pkg::is_xg_msb(in_ent.msb);
    req_next.bank_ok  = bank_seen && !bank_invalid;
    req_next.wide_en  = (in_ent.lsb != msel_pkg::XG_SFX_LSB) || !xg_system;
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      req <= req_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      xg_system <= 1'b0;
    end else if (cfg_we) begin
      xg_system <= cfg_wdata;
    end
  end

  // Entry count and XG bank validity
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      count        <= '0;
      bank_seen    <= 1'b0;
      bank_invalid <= 1'b0;
    end else if (do_load) begin
      count <= count + CW'(1);
      if (msel_pkg::is_xg_msb(in_ent.msb)) begin
        bank_seen <= 1'b1;
        if (!msel_pkg::xg_allowed(in_ent.prog)) begin
          bank_invalid <= 1'b1;
        end
      end
    end
  end

  msel_ram #(
    .WIDTH (msel_pkg::ENTRY_W),
    .DEPTH (MAX_PRESETS)
  ) u_table (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (count[AW-1:0]),
    .wr_data (in_ent),
    .rd_en   (rd_issue),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (rd_word)
  );

  assign rd_ent = rd_word;

  // Walk the read pointer and track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
    end
    if (do_lookup) begin
      rd_ptr <= '0;
    end else if (rd_issue) begin
      rd_ptr <= rd_ptr + CW'(1);
    end
    if (rd_issue) begin
      rd_idx <= rd_ptr[AW-1:0];
    end
  end

  msel_scan #(
    .AW (AW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (do_lookup),
    .req        (req),
    .ent_valid  (rd_pend),
    .ent_idx    (rd_idx),
    .ent        (rd_ent),
    .result_idx (result_idx)
  );

  // Sequence a lookup
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_lookup) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!rd_issue && !rd_pend) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register
  assign result_wide = {{IDX_W{1'b0}}, result_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == ST_DONE && out_free) begin
      out_idx   <= result_wide[IDX_W-1:0];
      out_empty <= (count == '0);
    end
  end

  assign m_tdata = {{(16 - IDX_W){1'b0}}, out_idx};
  assign m_tuser = out_empty;

endmodule
